// File: design/state_vector_gate_engine_unit_defines.svh
// assertion macros shared by the state vector gate engine rtl
`ifndef STATE_VECTOR_GATE_ENGINE_UNIT_DEFINES_SVH
`define STATE_VECTOR_GATE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SVGE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svge check failed: same cycle");

// next-cycle implication, checked out of reset
`define SVGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svge check failed: next cycle");

`endif

// File: design/svge_pkg.sv
// shared types and constants of the state vector gate engine
package svge_pkg;

  // item kinds
  localparam logic [1:0] KIND_INIT = 2'd0;
  localparam logic [1:0] KIND_GATE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_BAD = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  // fixed field widths
  localparam int FRAC   = 14;
  localparam int M_BITS = 16;
  localparam int OUT_W  = 16;
  localparam int TGT_W  = 4;
  localparam int CFG_W  = 4;
  localparam logic [CFG_W-1:0] QUBITS_RST = 4'd10;

  // control passed with each operand pair into the multiply-accumulate unit
  typedef struct packed {
    logic       vld;
    logic       neg;
    logic       first;
    logic       last;
    logic [1:0] slot;
  } mac_ctl_t;

endpackage

// File: design/svge_ram.sv
// generic single-write, single-read ram with registered read data
module svge_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/svge_mac.sv
// shared multiplier and accumulator with rounding and saturation
module svge_mac import svge_pkg::*; #(
  parameter int AMP_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl_i,
  input  logic signed [M_BITS-1:0]   m_i,
  input  logic signed [AMP_BITS-1:0] x_i,
  output logic signed [AMP_BITS-1:0] res_o,
  output logic                       res_vld_o,
  output logic [1:0]                 res_slot_o,
  output logic                       sat_o
);

  localparam int PW    = M_BITS + AMP_BITS;
  localparam int ACC_W = PW + 2;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] HI  =
    {{(ACC_W-AMP_BITS+1){1'b0}}, {(AMP_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] LO  =
    {{(ACC_W-AMP_BITS+1){1'b1}}, {(AMP_BITS-1){1'b0}}};

  logic signed [PW-1:0]    p_r;
  mac_ctl_t                ctl_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] rnd;
  logic                    over_hi;
  logic                    under_lo;

  // multiply stage
  always_ff @(posedge clk) begin
    p_r <= m_i * x_i;
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  // accumulate, round half up, saturate
  always_comb begin
    term     = ctl_r.neg ? -ACC_W'(p_r) : ACC_W'(p_r);
    sum      = (ctl_r.first ? '0 : acc_r) + term;
    rnd      = (sum + RND) >>> FRAC;
    over_hi  = rnd > HI;
    under_lo = rnd < LO;
  end

  always_ff @(posedge clk) begin
    if (ctl_r.vld) begin
      acc_r <= sum;
    end
    if (over_hi) begin
      res_o <= HI[AMP_BITS-1:0];
    end else if (under_lo) begin
      res_o <= LO[AMP_BITS-1:0];
    end else begin
      res_o <= rnd[AMP_BITS-1:0];
    end
    res_slot_o <= ctl_r.slot;
    if (!rst_n) begin
      res_vld_o <= 1'b0;
      sat_o     <= 1'b0;
    end else begin
      res_vld_o <= ctl_r.vld && ctl_r.last;
      sat_o     <= ctl_r.vld && ctl_r.last && (over_hi || under_lo);
    end
  end

endmodule

// File: design/state_vector_gate_engine_unit.sv
// top level of the state vector gate engine: sequencer, store and register port
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-------------------------------------
//  input     | start, busy (taken: start&!busy)| in_kind .. in_m11_im
//  result    | out_valid, one cycle strobe     | out_amp_re, out_amp_im, out_status
//  config    | psel/penable/pwrite/pready     | paddr, pwdata, prdata
//
// a gate scans the indices of the active qubits, and for each amplitude pair it
// touches, the one shared multiplier does 16 products.
// an init sweeps the whole store; a read returns one stored amplitude.
// items with a bad kind, index, target or control mask answer the next cycle without going busy.
// after reset a clearing pass over the whole store runs with busy high.
// results are shown for one cycle and the receiver cannot stall them.
module state_vector_gate_engine_unit import svge_pkg::*; #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic [TGT_W-1:0]             in_target,
  input  logic [MAX_QUBITS-1:0]        in_control_mask,
  input  logic [MAX_QUBITS-1:0]        in_basis_index,
  input  logic signed [M_BITS-1:0]     in_m00_re,
  input  logic signed [M_BITS-1:0]     in_m00_im,
  input  logic signed [M_BITS-1:0]     in_m01_re,
  input  logic signed [M_BITS-1:0]     in_m01_im,
  input  logic signed [M_BITS-1:0]     in_m10_re,
  input  logic signed [M_BITS-1:0]     in_m10_im,
  input  logic signed [M_BITS-1:0]     in_m11_re,
  input  logic signed [M_BITS-1:0]     in_m11_im,
  output logic                         out_valid,
  output logic signed [OUT_W-1:0]      out_amp_re,
  output logic signed [OUT_W-1:0]      out_amp_im,
  output logic [1:0]                   out_status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  `include "state_vector_gate_engine_unit_defines.svh"

  localparam int DEPTH = 1 << MAX_QUBITS;
  localparam int NQ_W  = $clog2(MAX_QUBITS + 1);
  localparam int WW    = 2 * AMP_BITS;
  localparam logic [AMP_BITS-1:0] ONE = AMP_BITS'(1 << FRAC);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_CLR   = 12'b0000_0000_0010,
    ST_SCAN  = 12'b0000_0000_0100,
    ST_RD_A  = 12'b0000_0000_1000,
    ST_RD_B  = 12'b0000_0001_0000,
    ST_LD_B  = 12'b0000_0010_0000,
    ST_MAC   = 12'b0000_0100_0000,
    ST_DRAIN = 12'b0000_1000_0000,
    ST_WR_A  = 12'b0001_0000_0000,
    ST_WR_B  = 12'b0010_0000_0000,
    ST_RD    = 12'b0100_0000_0000,
    ST_RD_W  = 12'b1000_0000_0000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CFG_W-1:0]            qubits_r;
  logic [MAX_QUBITS-1:0]       idx_r, idx_nxt;
  logic [MAX_QUBITS-1:0]       basis_r, basis_nxt;
  logic [MAX_QUBITS-1:0]       ts_r, ts_nxt;
  logic [MAX_QUBITS-1:0]       cmask_r, cmask_nxt;
  logic [MAX_QUBITS-1:0]       last_r, last_nxt;
  logic                        report_r, report_nxt;
  logic                        sat_r, sat_nxt;
  logic [3:0]                  k_r, k_nxt;
  logic signed [M_BITS-1:0]    m_r [8];
  logic signed [AMP_BITS-1:0]  a_re_r, a_im_r, b_re_r, b_im_r;
  logic signed [AMP_BITS-1:0]  res_r [4];
  logic                        out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]     out_re_r, out_re_nxt, out_im_r, out_im_nxt;
  logic [1:0]                  out_status_r, out_status_nxt;

  logic [NQ_W-1:0]             n_act;
  logic [MAX_QUBITS-1:0]       in_ts;
  logic                        accept;
  logic                        idx_bad;
  logic                        gate_bad;
  logic                        elig;
  logic                        we;
  logic [MAX_QUBITS-1:0]       waddr, raddr;
  logic [WW-1:0]               wdata, rdata;
  mac_ctl_t                    mac_ctl;
  logic signed [M_BITS-1:0]    mac_m;
  logic signed [AMP_BITS-1:0]  mac_x;
  logic signed [AMP_BITS-1:0]  mac_res;
  logic                        mac_vld;
  logic [1:0]                  mac_slot;
  logic                        mac_sat;
  logic                        cfg_we;

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32-CFG_W){1'b0}}, qubits_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qubits_r <= QUBITS_RST;
    end else if (cfg_we) begin
      qubits_r <= pwdata[CFG_W-1:0];
    end
  end

  // active qubit count, clamped into range
  always_comb begin
    if (qubits_r == '0) begin
      n_act = NQ_W'(1);
    end else if (int'(qubits_r) > MAX_QUBITS) begin
      n_act = NQ_W'(MAX_QUBITS);
    end else begin
      n_act = NQ_W'(qubits_r);
    end
  end

  // item checks at the moment of acceptance, pair eligibility during the scan, busy
  assign accept   = start && !busy;
  assign in_ts    = MAX_QUBITS'(1) << in_target;
  assign idx_bad  = (in_basis_index >> n_act) != '0;
  assign gate_bad = (int'(in_target) >= int'(n_act)) ||
                    ((in_control_mask & in_ts) != '0) ||
                    ((in_control_mask >> n_act) != '0);
  assign elig     = ((idx_r & ts_r) == '0) && ((idx_r & cmask_r) == cmask_r);
  assign busy     = (state_r != ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    basis_nxt      = basis_r;
    ts_nxt         = ts_r;
    cmask_nxt      = cmask_r;
    last_nxt       = last_r;
    report_nxt     = report_r;
    sat_nxt        = sat_r || mac_sat;
    k_nxt          = k_r;
    out_valid_nxt  = 1'b0;
    out_re_nxt     = '0;
    out_im_nxt     = '0;
    out_status_nxt = STATUS_OK;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_INIT: begin
              if (idx_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STATUS_BAD;
              end else begin
                basis_nxt  = in_basis_index;
                idx_nxt    = '0;
                report_nxt = 1'b1;
                state_nxt  = ST_CLR;
              end
            end
            KIND_GATE: begin
              if (gate_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STATUS_BAD;
              end else begin
                ts_nxt    = in_ts;
                cmask_nxt = in_control_mask;
                last_nxt  = ~({MAX_QUBITS{1'b1}} << n_act);
                idx_nxt   = '0;
                sat_nxt   = 1'b0;
                state_nxt = ST_SCAN;
              end
            end
            KIND_READ: begin
              if (idx_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STATUS_BAD;
              end else begin
                basis_nxt = in_basis_index;
                state_nxt = ST_RD;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STATUS_BAD;
            end
          endcase
        end
      end
      ST_CLR: begin
        if (idx_r == {MAX_QUBITS{1'b1}}) begin
          out_valid_nxt = report_r;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_SCAN: begin
        if (elig) begin
          state_nxt = ST_RD_A;
        end else if (idx_r == last_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sat_r ? STATUS_SAT : STATUS_OK;
          state_nxt      = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_RD_A: state_nxt = ST_RD_B;
      ST_RD_B: state_nxt = ST_LD_B;
      ST_LD_B: begin
        k_nxt     = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        k_nxt = k_r + 1'b1;
        if (k_r == 4'hF) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_WR_A;
      ST_WR_A:  state_nxt = ST_WR_B;
      ST_WR_B: begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_RD:    state_nxt = ST_RD_W;
      ST_RD_W: begin
        out_valid_nxt = 1'b1;
        out_re_nxt    = OUT_W'($signed(rdata[WW-1:AMP_BITS]));
        out_im_nxt    = OUT_W'($signed(rdata[AMP_BITS-1:0]));
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      idx_r       <= '0;
      basis_r     <= '0;
      report_r    <= 1'b0;
      sat_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      basis_r     <= basis_nxt;
      report_r    <= report_nxt;
      sat_r       <= sat_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ts_r         <= ts_nxt;
    cmask_r      <= cmask_nxt;
    last_r       <= last_nxt;
    out_re_r     <= out_re_nxt;
    out_im_r     <= out_im_nxt;
    out_status_r <= out_status_nxt;
  end

  // matrix held for the whole gate, operands and results of one pair
  always_ff @(posedge clk) begin
    if (accept && in_kind == KIND_GATE) begin
      m_r[0] <= in_m00_re;
      m_r[1] <= in_m00_im;
      m_r[2] <= in_m01_re;
      m_r[3] <= in_m01_im;
      m_r[4] <= in_m10_re;
      m_r[5] <= in_m10_im;
      m_r[6] <= in_m11_re;
      m_r[7] <= in_m11_im;
    end
    if (state_r == ST_RD_B) begin
      a_re_r <= rdata[WW-1:AMP_BITS];
      a_im_r <= rdata[AMP_BITS-1:0];
    end
    if (state_r == ST_LD_B) begin
      b_re_r <= rdata[WW-1:AMP_BITS];
      b_im_r <= rdata[AMP_BITS-1:0];
    end
    if (mac_vld) begin
      res_r[mac_slot] <= mac_res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_amp_re = out_re_r;
  assign out_amp_im = out_im_r;
  assign out_status = out_status_r;

  // store access
  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = {res_r[0], res_r[1]};
    raddr = idx_r;
    if (state_r == ST_CLR) begin
      we    = 1'b1;
      wdata = (idx_r == basis_r) ? {ONE, {AMP_BITS{1'b0}}} : '0;
    end else if (state_r == ST_WR_A) begin
      we = 1'b1;
    end else if (state_r == ST_WR_B) begin
      we    = 1'b1;
      waddr = idx_r | ts_r;
      wdata = {res_r[2], res_r[3]};
    end
    if (state_r == ST_RD_B) begin
      raddr = idx_r | ts_r;
    end else if (state_r == ST_RD) begin
      raddr = basis_r;
    end
  end

  svge_ram #(
    .WIDTH(WW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // operand selection: k = {row, part of result, column, cross term}
  always_comb begin
    mac_ctl.vld   = (state_r == ST_MAC);
    mac_ctl.neg   = !k_r[2] && k_r[0];
    mac_ctl.first = (k_r[1:0] == 2'd0);
    mac_ctl.last  = (k_r[1:0] == 2'd3);
    mac_ctl.slot  = k_r[3:2];
    mac_m         = m_r[{k_r[3], k_r[1], k_r[0]}];
    if (k_r[1]) begin
      mac_x = (k_r[2] ^ k_r[0]) ? b_im_r : b_re_r;
    end else begin
      mac_x = (k_r[2] ^ k_r[0]) ? a_im_r : a_re_r;
    end
  end

  svge_mac #(
    .AMP_BITS(AMP_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (mac_ctl),
    .m_i       (mac_m),
    .x_i       (mac_x),
    .res_o     (mac_res),
    .res_vld_o (mac_vld),
    .res_slot_o(mac_slot),
    .sat_o     (mac_sat)
  );

  // checks on the sequencer
  `SVGE_ASSERT_NEXT(a_sat_from_scan, clk, rst_n, state_nxt == ST_IDLE && out_valid_nxt && out_status_nxt == STATUS_SAT, $past(state_r == ST_SCAN))
  `SVGE_ASSERT_SAME(a_mac_result_slot, clk, rst_n, mac_vld, state_r == ST_MAC || state_r == ST_DRAIN || state_r == ST_WR_A)
  `SVGE_ASSERT_NEXT(a_pair_written, clk, rst_n, state_r == ST_WR_A, state_r == ST_WR_B && $past(mac_vld))
  `SVGE_ASSERT_NEXT(a_mac_starts, clk, rst_n, state_r == ST_LD_B, state_r == ST_MAC && k_r == 4'd0)

endmodule
